// ----- hw/rtl/dss_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// dss_pkg
// Shared types and codes of the duplicate-free set store.
// ---------------------------------------------------------------------------
package dss_pkg;

  localparam int CMD_W       = 2;
  localparam int LIST_W      = 3;
  localparam int ID_W        = 16;
  localparam int STATUS_W    = 3;
  localparam int COUNT_W     = 9;
  localparam int MASK_W      = 8;
  localparam int LIMIT_W     = 9;
  localparam int CFG_IDX_W   = 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QCNT_W      = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_ADDED    = 3'd0,
    STAT_DUP      = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_FOUND    = 3'd3,
    STAT_NOTFOUND = 3'd4,
    STAT_CLEARED  = 3'd5,
    STAT_RANGE    = 3'd6
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MASK  = 1'b0,
    CFG_LIMIT = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    B_INIT,
    B_IDLE,
    B_SRCH,
    B_SRCH_CMP,
    B_HIT_CMP,
    B_SHIFT_RD,
    B_SHIFT_WR,
    B_INSERT,
    B_BM_CHK,
    B_CLEAR,
    B_RESP
  } back_state_e;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic              list_ok;
    logic [LIST_W-1:0] list_idx;
    logic              sorted;
    logic              id_range;
    logic [ID_W-1:0]   id;
  } item_t;

endpackage
`default_nettype wire

// ----- hw/rtl/dedup_set_store.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// dedup_set_store
// Bank of duplicate-free id sets with bitmap or sorted-array membership.
// ---------------------------------------------------------------------------
// After reset the presence bits are swept clear, one entry per cycle, over all
// NUM_LISTS*LIST_CAPACITY entries before the first item is executed. Items are
// queued by the front and executed one at a time by the back, which owns a
// sorted id memory with one read and one write port. A sorted query is a binary
// search over the n entries of the list (one memory read and one compare per
// search step); a sorted add then shifts each larger entry up with one read and
// one write per entry, and inserts the id. Bitmap add and query read the
// presence bit and then respond; clear sweeps the list, one presence bit per
// cycle; out-of-range items go straight to the response.
// ---------------------------------------------------------------------------
module dedup_set_store #(
  parameter int NUM_LISTS     = 8,
  parameter int LIST_CAPACITY = 256,
  parameter int ID_BITS       = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [dss_pkg::CMD_W-1:0]      cmd_i,
  input  wire logic [dss_pkg::LIST_W-1:0]     list_index_i,
  input  wire logic [dss_pkg::ID_W-1:0]       id_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [dss_pkg::STATUS_W-1:0]        status_o,
  output logic [dss_pkg::COUNT_W-1:0]         entry_count_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [dss_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [dss_pkg::LIMIT_W-1:0]    cfg_data_i
);

  logic [dss_pkg::MASK_W-1:0]   mask_q;
  logic [dss_pkg::LIMIT_W-1:0]  limit_q;
  logic                         q_push, q_full, q_valid, q_pop;
  dss_pkg::item_t               q_in, q_out;
  logic [dss_pkg::QCNT_W-1:0]   q_count;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= '0;
      limit_q <= dss_pkg::LIMIT_W'(256);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        dss_pkg::CFG_MASK:  mask_q  <= cfg_data_i[dss_pkg::MASK_W-1:0];
        dss_pkg::CFG_LIMIT: limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dss_front #(
    .NUM_LISTS     (NUM_LISTS),
    .LIST_CAPACITY (LIST_CAPACITY),
    .ID_BITS       (ID_BITS)
  ) u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .list_index_i  (list_index_i),
    .id_i          (id_i),
    .sorted_mask_i (mask_q),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_item_o      (q_in)
  );

  dss_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .item_o  (q_out),
    .count_o (q_count)
  );

  dss_back #(
    .NUM_LISTS     (NUM_LISTS),
    .LIST_CAPACITY (LIST_CAPACITY),
    .ID_BITS       (ID_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (q_out),
    .q_pop_o       (q_pop),
    .entry_limit_i (limit_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

  // an accepted item always finds room in the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> (32'(q_count) < dss_pkg::QUEUE_DEPTH))
    else $error("queue overflow");

  // reported counts never exceed a list's capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(entry_count_o) <= LIST_CAPACITY))
    else $error("entry count above capacity");

  // a pop only happens when the queue holds an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (q_count != '0))
    else $error("pop from empty queue");

endmodule
`default_nettype wire

// ----- hw/rtl/dss_front.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// dss_front
// Accepts items, masks the id and classifies list, mode and id range.
// ---------------------------------------------------------------------------
module dss_front #(
  parameter int NUM_LISTS     = 8,
  parameter int LIST_CAPACITY = 256,
  parameter int ID_BITS       = 16
) (
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [dss_pkg::CMD_W-1:0]   cmd_i,
  input  wire logic [dss_pkg::LIST_W-1:0]  list_index_i,
  input  wire logic [dss_pkg::ID_W-1:0]    id_i,
  input  wire logic [dss_pkg::MASK_W-1:0]  sorted_mask_i,
  input  wire logic                        q_full_i,
  output logic                             q_push_o,
  output dss_pkg::item_t                   q_item_o
);

  localparam int IdMaskW = (ID_BITS < dss_pkg::ID_W) ? ID_BITS : dss_pkg::ID_W;

  logic [dss_pkg::ID_W-1:0] id_m;

  assign id_m = id_i & dss_pkg::ID_W'((32'h1 << IdMaskW) - 32'h1);

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i & ~q_full_i;

  always_comb begin
    q_item_o.cmd      = cmd_i;
    q_item_o.list_ok  = (32'(list_index_i) < 32'(NUM_LISTS));
    q_item_o.list_idx = list_index_i;
    q_item_o.sorted   = sorted_mask_i[list_index_i];
    q_item_o.id_range = (32'(id_m) >= 32'(LIST_CAPACITY));
    q_item_o.id       = id_m;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/dss_fifo.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// dss_fifo
// Short item queue between the front and the back.
// ---------------------------------------------------------------------------
module dss_fifo (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  input  wire dss_pkg::item_t               item_i,
  output logic                              full_o,
  output logic                              valid_o,
  input  wire logic                         pop_i,
  output dss_pkg::item_t                    item_o,
  output logic [dss_pkg::QCNT_W-1:0]        count_o
);

  dss_pkg::item_t                 mem_q [dss_pkg::QUEUE_DEPTH];
  logic                           wptr_q, wptr_d;
  logic                           rptr_q, rptr_d;
  logic [dss_pkg::QCNT_W-1:0]     cnt_q, cnt_d;
  logic                           do_push, do_pop;

  assign full_o  = (cnt_q == dss_pkg::QCNT_W'(dss_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rptr_q];
  assign count_o = cnt_q;
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wptr_d = do_push ? ~wptr_q : wptr_q;
    rptr_d = do_pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + dss_pkg::QCNT_W'(do_push) - dss_pkg::QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/dss_back.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// dss_back
// Executes items: binary search and shifted insert, bitmap lookup, list clear,
// and holds the result register.
// ---------------------------------------------------------------------------
module dss_back #(
  parameter int NUM_LISTS     = 8,
  parameter int LIST_CAPACITY = 256,
  parameter int ID_BITS       = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          q_valid_i,
  input  wire dss_pkg::item_t                q_item_i,
  output logic                               q_pop_o,
  input  wire logic [dss_pkg::LIMIT_W-1:0]   entry_limit_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [dss_pkg::STATUS_W-1:0]       status_o,
  output logic [dss_pkg::COUNT_W-1:0]        entry_count_o
);

  localparam int IdW  = (ID_BITS < dss_pkg::ID_W) ? ID_BITS : dss_pkg::ID_W;
  localparam int Tot  = NUM_LISTS * LIST_CAPACITY;
  localparam int AW   = (Tot > 1) ? $clog2(Tot) : 1;
  localparam int CNW  = $clog2(LIST_CAPACITY + 1);
  localparam int LW   = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;

  function automatic logic [AW-1:0] addr_of(input logic [dss_pkg::LIST_W-1:0] li,
                                            input logic [CNW-1:0] off);
    return AW'(32'(li) * LIST_CAPACITY + 32'(off));
  endfunction

  logic [IdW-1:0] sorted_mem [Tot];
  logic [IdW-1:0] order_mem  [Tot];
  logic           pres_mem   [Tot];

  dss_pkg::back_state_e          state_q, state_d;
  dss_pkg::item_t                item_q, item_d;
  logic [CNW-1:0]                n_q, n_d, lo_q, lo_d, hi_q, hi_d, k_q, k_d;
  logic [AW-1:0]                 sweep_q, sweep_d;
  logic [CNW-1:0]                counts_q [NUM_LISTS];
  logic                          cnt_we;
  logic [LW-1:0]                 cnt_widx;
  logic [CNW-1:0]                cnt_wdata;
  logic [dss_pkg::STATUS_W-1:0]  res_q, res_d;
  logic [CNW-1:0]                rcnt_q, rcnt_d;
  logic                          out_valid_q, out_valid_d;
  logic [dss_pkg::STATUS_W-1:0]  out_status_q, out_status_d;
  logic [dss_pkg::COUNT_W-1:0]   out_count_q, out_count_d;

  logic                          s_we, o_we, p_we, p_wdata, p_rdata_q;
  logic [AW-1:0]                 s_raddr, s_waddr, o_waddr, p_raddr, p_waddr;
  logic [IdW-1:0]                s_wdata, s_rdata_q;

  logic                          decide, hit, sorted_full;
  logic [CNW-1:0]                mid, n_in;
  logic [IdW-1:0]                id_k;

  assign id_k = item_q.id[IdW-1:0];
  assign mid  = lo_q + ((hi_q - lo_q) >> 1);
  assign n_in = q_item_i.list_ok ? counts_q[q_item_i.list_idx[LW-1:0]] : '0;
  assign sorted_full = (32'(n_q) >= 32'(entry_limit_i)) ||
                       (32'(n_q) >= 32'(LIST_CAPACITY));

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    n_d         = n_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    k_d         = k_q;
    sweep_d     = sweep_q;
    res_d       = res_q;
    rcnt_d      = rcnt_q;
    q_pop_o     = 1'b0;
    cnt_we      = 1'b0;
    cnt_widx    = item_q.list_idx[LW-1:0];
    cnt_wdata   = '0;
    s_we        = 1'b0;
    s_waddr     = addr_of(item_q.list_idx, k_q);
    s_wdata     = s_rdata_q;
    s_raddr     = addr_of(item_q.list_idx, mid);
    o_we        = 1'b0;
    o_waddr     = addr_of(item_q.list_idx, n_q);
    p_we        = 1'b0;
    p_wdata     = 1'b0;
    p_waddr     = sweep_q;
    p_raddr     = addr_of(q_item_i.list_idx, CNW'(q_item_i.id));
    decide      = 1'b0;
    hit         = 1'b0;
    out_valid_d  = out_valid_q & out_stall_i;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;

    unique case (state_q)
      dss_pkg::B_INIT: begin
        p_we    = 1'b1;
        sweep_d = sweep_q + AW'(1);
        if (sweep_q == AW'(Tot - 1)) begin
          state_d = dss_pkg::B_IDLE;
        end
      end
      dss_pkg::B_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          item_d  = q_item_i;
          n_d     = n_in;
          lo_d    = '0;
          hi_d    = n_in;
          k_d     = '0;
          if (!q_item_i.list_ok) begin
            res_d   = dss_pkg::STAT_RANGE;
            rcnt_d  = '0;
            state_d = dss_pkg::B_RESP;
          end else if (q_item_i.cmd == dss_pkg::CMD_CLEAR) begin
            cnt_we   = 1'b1;
            cnt_widx = q_item_i.list_idx[LW-1:0];
            res_d    = dss_pkg::STAT_CLEARED;
            rcnt_d   = '0;
            state_d  = dss_pkg::B_CLEAR;
          end else if (q_item_i.sorted) begin
            state_d = dss_pkg::B_SRCH;
          end else if (q_item_i.id_range) begin
            res_d   = dss_pkg::STAT_RANGE;
            rcnt_d  = n_in;
            state_d = dss_pkg::B_RESP;
          end else begin
            state_d = dss_pkg::B_BM_CHK;
          end
        end
      end
      dss_pkg::B_SRCH: begin
        if (lo_q < hi_q) begin
          k_d     = mid;
          state_d = dss_pkg::B_SRCH_CMP;
        end else if (lo_q < n_q) begin
          s_raddr = addr_of(item_q.list_idx, lo_q);
          state_d = dss_pkg::B_HIT_CMP;
        end else begin
          decide = 1'b1;
        end
      end
      dss_pkg::B_SRCH_CMP: begin
        if (s_rdata_q < id_k) begin
          lo_d = k_q + CNW'(1);
        end else begin
          hi_d = k_q;
        end
        state_d = dss_pkg::B_SRCH;
      end
      dss_pkg::B_HIT_CMP: begin
        decide = 1'b1;
        hit    = (s_rdata_q == id_k);
      end
      dss_pkg::B_SHIFT_RD: begin
        if (k_q > lo_q) begin
          s_raddr = addr_of(item_q.list_idx, k_q - CNW'(1));
          state_d = dss_pkg::B_SHIFT_WR;
        end else begin
          state_d = dss_pkg::B_INSERT;
        end
      end
      dss_pkg::B_SHIFT_WR: begin
        s_we    = 1'b1;
        k_d     = k_q - CNW'(1);
        state_d = dss_pkg::B_SHIFT_RD;
      end
      dss_pkg::B_INSERT: begin
        s_we      = 1'b1;
        s_waddr   = addr_of(item_q.list_idx, lo_q);
        s_wdata   = id_k;
        o_we      = 1'b1;
        cnt_we    = 1'b1;
        cnt_wdata = n_q + CNW'(1);
        res_d     = dss_pkg::STAT_ADDED;
        rcnt_d    = n_q + CNW'(1);
        state_d   = dss_pkg::B_RESP;
      end
      dss_pkg::B_BM_CHK: begin
        rcnt_d  = n_q;
        state_d = dss_pkg::B_RESP;
        if (item_q.cmd != dss_pkg::CMD_ADD) begin
          res_d = p_rdata_q ? dss_pkg::STAT_FOUND : dss_pkg::STAT_NOTFOUND;
        end else if (p_rdata_q) begin
          res_d = dss_pkg::STAT_DUP;
        end else if (32'(n_q) >= 32'(LIST_CAPACITY)) begin
          res_d = dss_pkg::STAT_FULL;
        end else begin
          p_we      = 1'b1;
          p_wdata   = 1'b1;
          p_waddr   = addr_of(item_q.list_idx, CNW'(item_q.id));
          o_we      = 1'b1;
          cnt_we    = 1'b1;
          cnt_wdata = n_q + CNW'(1);
          res_d     = dss_pkg::STAT_ADDED;
          rcnt_d    = n_q + CNW'(1);
        end
      end
      dss_pkg::B_CLEAR: begin
        p_we    = 1'b1;
        p_waddr = addr_of(item_q.list_idx, k_q);
        k_d     = k_q + CNW'(1);
        if (k_q == CNW'(LIST_CAPACITY - 1)) begin
          state_d = dss_pkg::B_RESP;
        end
      end
      dss_pkg::B_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_q;
          out_count_d  = dss_pkg::COUNT_W'(rcnt_q);
          state_d      = dss_pkg::B_IDLE;
        end
      end
      default: begin
        state_d = dss_pkg::B_IDLE;
      end
    endcase

    if (decide) begin
      rcnt_d  = n_q;
      state_d = dss_pkg::B_RESP;
      if (item_q.cmd != dss_pkg::CMD_ADD) begin
        res_d = hit ? dss_pkg::STAT_FOUND : dss_pkg::STAT_NOTFOUND;
      end else if (hit) begin
        res_d = dss_pkg::STAT_DUP;
      end else if (sorted_full) begin
        res_d = dss_pkg::STAT_FULL;
      end else begin
        k_d     = n_q;
        state_d = dss_pkg::B_SHIFT_RD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dss_pkg::B_INIT;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_LISTS; i++) begin
        counts_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      out_valid_q <= out_valid_d;
      if (cnt_we) begin
        counts_q[cnt_widx] <= cnt_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    n_q          <= n_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    k_q          <= k_d;
    res_q        <= res_d;
    rcnt_q       <= rcnt_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  // sorted id rows
  always_ff @(posedge clk_i) begin
    if (s_we) begin
      sorted_mem[s_waddr] <= s_wdata;
    end
    s_rdata_q <= sorted_mem[s_raddr];
  end

  // insertion order rows
  always_ff @(posedge clk_i) begin
    if (o_we) begin
      order_mem[o_waddr] <= id_k;
    end
  end

  // presence bits
  always_ff @(posedge clk_i) begin
    if (p_we) begin
      pres_mem[p_waddr] <= p_wdata;
    end
    p_rdata_q <= pres_mem[p_raddr];
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign entry_count_o = out_count_q;

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for dedup_set_store: directed and random add, query
// and clear items across bitmap and sorted lists, with random source and
// sink idling, a long sink hold-off, and register writes between phases.
// ---------------------------------------------------------------------------
module tb;

  localparam int NLISTS = 8;
  localparam int CAP    = 256;
  localparam int WDOG   = 200000;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [dss_pkg::CMD_W-1:0]     cmd_i;
  logic [dss_pkg::LIST_W-1:0]    list_index_i;
  logic [dss_pkg::ID_W-1:0]      id_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [dss_pkg::STATUS_W-1:0]  status_o;
  logic [dss_pkg::COUNT_W-1:0]   entry_count_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [dss_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [dss_pkg::LIMIT_W-1:0]   cfg_data_i;

  dedup_set_store u_dut (.*);

  typedef struct packed {
    logic [dss_pkg::STATUS_W-1:0] status;
    logic [dss_pkg::COUNT_W-1:0]  count;
  } resp_t;

  // mirror of the set bank
  logic [dss_pkg::ID_W-1:0]    srt_mem [NLISTS][CAP];
  logic                        present [NLISTS][CAP];
  logic [dss_pkg::COUNT_W-1:0] counts  [NLISTS];
  logic [dss_pkg::MASK_W-1:0]  mode_mask;
  logic [dss_pkg::LIMIT_W-1:0] add_limit;
  // sorted rows valid only when built entirely in sorted mode
  logic                        srt_ok  [NLISTS];

  resp_t resp_q[$];
  int    errors;
  int    idle_cycles;
  bit    src_idle_en;
  bit    snk_idle_en;
  bit    hold_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic resp_t predict_set_op(logic [dss_pkg::CMD_W-1:0] c, int li,
                                           logic [dss_pkg::ID_W-1:0] id);
    resp_t r;
    int n, lo, hi, mid, lim;
    bit hit;
    n = counts[li];
    if (c == dss_pkg::CMD_CLEAR) begin
      for (int k = 0; k < CAP; k++) present[li][k] = 1'b0;
      counts[li] = '0;
      srt_ok[li] = 1'b1;
      r.status = dss_pkg::STAT_CLEARED;
    end else if (mode_mask[li]) begin
      lo = 0;
      hi = n;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (srt_mem[li][mid] < id) lo = mid + 1;
        else hi = mid;
      end
      hit = (lo < n) && (srt_mem[li][lo] == id);
      lim = (add_limit > CAP) ? CAP : add_limit;
      if (c != dss_pkg::CMD_ADD) r.status = hit ? dss_pkg::STAT_FOUND : dss_pkg::STAT_NOTFOUND;
      else if (hit) r.status = dss_pkg::STAT_DUP;
      else if (n >= lim) r.status = dss_pkg::STAT_FULL;
      else begin
        for (int k = n; k > lo; k--) srt_mem[li][k] = srt_mem[li][k-1];
        srt_mem[li][lo] = id;
        counts[li] = n + 1;
        r.status = dss_pkg::STAT_ADDED;
      end
    end else begin
      if (id >= CAP) r.status = dss_pkg::STAT_RANGE;
      else if (c != dss_pkg::CMD_ADD)
        r.status = present[li][id] ? dss_pkg::STAT_FOUND : dss_pkg::STAT_NOTFOUND;
      else if (present[li][id]) r.status = dss_pkg::STAT_DUP;
      else if (n >= CAP) r.status = dss_pkg::STAT_FULL;
      else begin
        present[li][id] = 1'b1;
        counts[li] = n + 1;
        srt_ok[li] = 1'b0;
        r.status = dss_pkg::STAT_ADDED;
      end
    end
    r.count = counts[li];
    return r;
  endfunction

  task automatic send_item(logic [dss_pkg::CMD_W-1:0] c, int li, logic [dss_pkg::ID_W-1:0] id);
    int gap;
    // a sorted list with bitmap-built entries must never be searched
    if (c != dss_pkg::CMD_CLEAR && mode_mask[li] && !srt_ok[li]) c = dss_pkg::CMD_CLEAR;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_i <= c;
    list_index_i <= li[dss_pkg::LIST_W-1:0];
    id_i <= id;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    resp_q.insert(resp_q.size(), predict_set_op(c, li, id));
  endtask

  task automatic drain_wait();
    in_valid_i <= 1'b0;
    while (resp_q.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  task automatic write_reg(dss_pkg::cfg_idx_e idx, logic [dss_pkg::LIMIT_W-1:0] data);
    drain_wait();
    cfg_index_i <= idx;
    cfg_data_i <= data;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == dss_pkg::CFG_MASK) mode_mask = data[dss_pkg::MASK_W-1:0];
    else add_limit = data;
  endtask

  // sink: random stall bursts and an on-demand long hold-off
  initial begin
    int n;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 11);
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    resp_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (resp_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item status=%0d count=%0d", status_o, entry_count_o);
      end else begin
        e = resp_q.pop_front();
        if (e.status !== status_o || e.count !== entry_count_o) begin
          errors++;
          if (errors <= 10)
            $display("mismatch status exp %0d got %0d count exp %0d got %0d",
                     e.status, status_o, e.count, entry_count_o);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic test_bitmap_directed();
    send_item(dss_pkg::CMD_QUERY, 0, 16'd5);
    send_item(dss_pkg::CMD_ADD, 0, 16'd5);
    send_item(dss_pkg::CMD_ADD, 0, 16'd5);
    send_item(dss_pkg::CMD_QUERY, 0, 16'd5);
    send_item(dss_pkg::CMD_ADD, 0, 16'd0);
    send_item(dss_pkg::CMD_ADD, 0, 16'd255);
    send_item(dss_pkg::CMD_ADD, 0, 16'd256);
    send_item(dss_pkg::CMD_QUERY, 0, 16'hFFFF);
    send_item(2'd3, 0, 16'd5);
    send_item(dss_pkg::CMD_CLEAR, 0, 16'hFFFF);
    send_item(dss_pkg::CMD_QUERY, 0, 16'd5);
    send_item(dss_pkg::CMD_ADD, 7, 16'hAAAA);
  endtask

  task automatic test_sorted_directed();
    write_reg(dss_pkg::CFG_MASK, 9'h0FF);
    write_reg(dss_pkg::CFG_LIMIT, 9'd3);
    for (int k = 0; k < NLISTS; k++) send_item(dss_pkg::CMD_CLEAR, k, '0);
    send_item(dss_pkg::CMD_ADD, 1, 16'hFFFF);
    send_item(dss_pkg::CMD_ADD, 1, 16'd0);
    send_item(dss_pkg::CMD_ADD, 1, 16'h5555);
    send_item(dss_pkg::CMD_ADD, 1, 16'h1234);
    send_item(dss_pkg::CMD_ADD, 1, 16'd0);
    send_item(dss_pkg::CMD_QUERY, 1, 16'h5555);
    send_item(dss_pkg::CMD_QUERY, 1, 16'h5556);
    send_item(2'd3, 1, 16'hFFFF);
    write_reg(dss_pkg::CFG_LIMIT, 9'd0);
    send_item(dss_pkg::CMD_ADD, 2, 16'd7);
  endtask

  task automatic random_phase(int cnt, int range_max);
    logic [dss_pkg::CMD_W-1:0] c;
    int r;
    for (int i = 0; i < cnt; i++) begin
      r = $urandom_range(0, 99);
      c = (r < 55) ? dss_pkg::CMD_ADD : (r < 90) ? dss_pkg::CMD_QUERY :
          (r < 93) ? dss_pkg::CMD_CLEAR : 2'd3;
      send_item(c, $urandom_range(0, NLISTS - 1),
                ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, range_max)));
    end
  endtask

  task automatic test_random_modes();
    write_reg(dss_pkg::CFG_LIMIT, 9'd256);
    write_reg(dss_pkg::CFG_MASK, 9'h0A5);
    for (int k = 0; k < NLISTS; k++) send_item(dss_pkg::CMD_CLEAR, k, '0);
    random_phase(120, 300);
    write_reg(dss_pkg::CFG_LIMIT, 9'd1);
    random_phase(60, 40);
    write_reg(dss_pkg::CFG_LIMIT, 9'd20);
    write_reg(dss_pkg::CFG_MASK, 9'h000);
    random_phase(80, 63);
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    src_idle_en = 1'b0;
    for (int i = 0; i < 20; i++)
      send_item(dss_pkg::CMD_QUERY, $urandom_range(0, 7), 16'($urandom_range(0, 255)));
    src_idle_en = 1'b1;
  endtask

  task automatic test_tail_no_idle();
    drain_wait();
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    write_reg(dss_pkg::CFG_MASK, 9'h0F0);
    for (int k = 4; k < NLISTS; k++) send_item(dss_pkg::CMD_CLEAR, k, '0);
    random_phase(100, 255);
  endtask

  initial begin
    errors = 0;
    hold_req = 1'b0;
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    cmd_i = '0;
    list_index_i = '0;
    id_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = dss_pkg::CFG_MASK;
    cfg_data_i = '0;
    mode_mask = '0;
    add_limit = 9'd256;
    for (int l = 0; l < NLISTS; l++) begin
      counts[l] = '0;
      srt_ok[l] = 1'b1;
      for (int k = 0; k < CAP; k++) begin
        present[l][k] = 1'b0;
        srt_mem[l][k] = '0;
      end
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_bitmap_directed();
    test_sorted_directed();
    test_random_modes();
    test_backpressure();
    test_tail_no_idle();
    drain_wait();
    if (errors == 0 && resp_q.size() == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/dss_pkg.sv
hw/rtl/dss_front.sv
hw/rtl/dss_fifo.sv
hw/rtl/dss_back.sv
hw/rtl/dedup_set_store.sv
dv/tb.sv
